FILE: hdl/mfht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfht_pkg;

  localparam int NUM_MOTORS      = 8;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int ROUND_BITS      = 24;

  localparam int SLOT_W   = 3;
  localparam int LEN_W    = 4;
  localparam int ENC_W    = 13;
  localparam int SPD_W    = 16;
  localparam int CUR_W    = 16;
  localparam int TEMP_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 8;
  localparam int TOTAL_W  = 37;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W   = ENC_W + 2;

  localparam int CPT_BITS = $clog2(COUNTS_PER_TURN);
  localparam int MEM_AW   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  localparam logic [LEN_W-1:0] FRAME_BYTES = LEN_W'(8);
  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(COUNTS_PER_TURN / 2);

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OFFLINE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ONLINE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERTEMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] present_mask;
    logic [CFG_W-1:0] overheat_limit;
    logic [CFG_W-1:0] recover_margin;
    logic [CFG_W-1:0] online_reload;
  } cfg_t;

  typedef struct packed {
    logic                     opcode;
    logic [SLOT_W-1:0]        motor_index;
    logic [LEN_W-1:0]         frame_length;
    logic [ENC_W-1:0]         encoder_angle;
    logic signed [SPD_W-1:0]  speed_rpm;
    logic signed [CUR_W-1:0]  current_raw;
    logic [TEMP_W-1:0]        temperature;
  } item_t;

  typedef struct packed {
    logic [ENC_W-1:0]      last_encoder;
    logic [ROUND_BITS-1:0] round_count;
    logic [STAT_W-1:0]     health_status;
    logic [CNT_W-1:0]      online_counter;
    logic [TEMP_W-1:0]     last_temperature;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [SLOT_W-1:0]         motor_slot;
    logic [STAT_W-1:0]         motor_status;
    logic signed [TOTAL_W-1:0] total_count;
    logic signed [SPD_W-1:0]   speed_out;
    logic signed [CUR_W-1:0]   current_out;
    logic                      frame_accepted;
    logic                      drive_enable;
    logic                      zero_command;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/mfht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mfht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/mfht_update.sv
`timescale 1ns / 1ps
`default_nettype none

module mfht_update
  import mfht_pkg::*;
(
  input  wire item_t   item_i,
  input  wire entry_t  entry_i,
  input  wire cfg_t    cfg_i,
  output logic         we_o,
  output entry_t       entry_o,
  output result_t      result_o
);

  logic                      in_range;
  logic                      present;
  logic                      frame_ok;
  logic                      tick_ok;
  logic signed [DIFF_W-1:0]  diff;
  logic [TEMP_W:0]           recover_sum;
  logic signed [TOTAL_W-1:0] rounds_ext;
  entry_t                    nxt;
  logic                      drive;
  logic                      zero_cmd;

  assign in_range = ({1'b0, item_i.motor_index} < (SLOT_W + 1)'(NUM_MOTORS));
  assign present  = in_range && cfg_i.present_mask[item_i.motor_index];
  assign frame_ok = present && (item_i.opcode == OP_FRAME)
                    && (item_i.frame_length == FRAME_BYTES);
  assign tick_ok  = present && (item_i.opcode == OP_TICK)
                    && (entry_i.health_status == ST_ONLINE);

  assign diff = $signed({2'b00, item_i.encoder_angle}) - $signed({2'b00, entry_i.last_encoder});
  assign recover_sum = {1'b0, item_i.temperature} + {1'b0, cfg_i.recover_margin};

  always_comb begin
    nxt      = entry_i;
    drive    = 1'b0;
    zero_cmd = 1'b0;
    if (frame_ok) begin
      if (diff < -HALF_TURN) begin
        nxt.round_count = entry_i.round_count + ROUND_BITS'(1);
      end else if (diff > HALF_TURN) begin
        nxt.round_count = entry_i.round_count - ROUND_BITS'(1);
      end
      nxt.last_encoder     = item_i.encoder_angle;
      nxt.last_temperature = item_i.temperature;
      nxt.online_counter   = cfg_i.online_reload;
      if (entry_i.health_status != ST_OVERTEMP) begin
        nxt.health_status = ST_ONLINE;
      end else if (recover_sum <= {1'b0, cfg_i.overheat_limit}) begin
        nxt.health_status = ST_ONLINE;
      end
    end else if (tick_ok) begin
      if (entry_i.online_counter <= CNT_W'(1)) begin
        nxt.online_counter = '0;
        nxt.health_status  = ST_OFFLINE;
        zero_cmd           = 1'b1;
      end else begin
        nxt.online_counter = entry_i.online_counter - CNT_W'(1);
        if (entry_i.last_temperature > cfg_i.overheat_limit) begin
          nxt.health_status = ST_OVERTEMP;
          zero_cmd          = 1'b1;
        end else begin
          drive = 1'b1;
        end
      end
    end
  end

  assign rounds_ext = TOTAL_W'($signed(nxt.round_count));

  assign we_o    = in_range;
  assign entry_o = nxt;

  always_comb begin
    result_o                = '0;
    result_o.motor_slot     = item_i.motor_index;
    if (in_range) begin
      result_o.motor_status   = nxt.health_status;
      result_o.total_count    = (rounds_ext <<< CPT_BITS) + TOTAL_W'(nxt.last_encoder);
      result_o.frame_accepted = frame_ok;
      result_o.drive_enable   = drive;
      result_o.zero_command   = zero_cmd;
      if (frame_ok) begin
        result_o.speed_out   = item_i.speed_rpm;
        result_o.current_out = item_i.current_raw;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/motor_feedback_health_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Tracks feedback and health of up to NUM_MOTORS motor slots. Each request on the
// input stream is a feedback frame (tuser 0) or a control tick (tuser 1) and yields
// exactly one result. Per-slot state lives in a table with a single read port and a
// registered read: in S_IDLE a request is taken and its slot entry is read; in S_EXEC,
// once the output register is empty or m_axis_tready is high, the entry is updated,
// written back and the output register is loaded. No new request is taken before that.
// After reset every slot reads as zero/offline through per-slot valid bits; no
// clearing pass is needed. Configuration writes are taken in any cycle.

module motor_feedback_health_tracker_core
  import mfht_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // motor_index[2:0], frame_length[6:3], encoder_angle[19:7], speed_rpm[35:20],
  // current_raw[51:36], temperature[59:52], zero [63:60]
  input  wire logic [63:0]          s_axis_tdata,
  // opcode[0]
  input  wire logic                 s_axis_tuser,

  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // motor_slot[2:0], motor_status[4:3], total_count[41:5], speed_out[57:42],
  // current_out[73:58], frame_accepted[74], drive_enable[75], zero_command[76],
  // zero [79:77]
  output logic [79:0]               m_axis_tdata,

  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  cfg_t              cfg_q, cfg_d;
  item_t             item_q;
  item_t             item_in;
  logic [NUM_MOTORS-1:0] valid_q, valid_d;
  result_t           res_q;
  result_t           res_new;
  logic              m_valid_q, m_valid_d;

  logic              s_accept;
  logic              finish;
  logic              upd_we;
  entry_t            rd_entry;
  entry_t            entry_rd;
  entry_t            entry_wr;
  logic [ENTRY_W-1:0] rd_raw;
  logic [MEM_AW-1:0] slot_addr;

  assign item_in.opcode        = s_axis_tuser;
  assign item_in.motor_index   = s_axis_tdata[2:0];
  assign item_in.frame_length  = s_axis_tdata[6:3];
  assign item_in.encoder_angle = s_axis_tdata[19:7];
  assign item_in.speed_rpm     = s_axis_tdata[35:20];
  assign item_in.current_raw   = s_axis_tdata[51:36];
  assign item_in.temperature   = s_axis_tdata[59:52];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign finish        = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign slot_addr = item_q.motor_index[MEM_AW-1:0];

  mfht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_MOTORS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (finish && upd_we),
    .waddr_i (slot_addr),
    .wdata_i (entry_wr),
    .re_i    (s_accept),
    .raddr_i (item_in.motor_index[MEM_AW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign entry_rd = valid_q[slot_addr] ? rd_entry : '0;

  mfht_update u_update (
    .item_i   (item_q),
    .entry_i  (entry_rd),
    .cfg_i    (cfg_q),
    .we_o     (upd_we),
    .entry_o  (entry_wr),
    .result_o (res_new)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_accept) state_d = S_EXEC;
      S_EXEC: if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (finish && upd_we) begin
      valid_d[slot_addr] = 1'b1;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (finish) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRESENT: cfg_d.present_mask   = cfg_data_i;
        CFG_LIMIT:   cfg_d.overheat_limit = cfg_data_i;
        CFG_MARGIN:  cfg_d.recover_margin = cfg_data_i;
        CFG_RELOAD:  cfg_d.online_reload  = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      valid_q              <= '0;
      m_valid_q            <= 1'b0;
      cfg_q.present_mask   <= 8'd0;
      cfg_q.overheat_limit <= 8'd80;
      cfg_q.recover_margin <= 8'd10;
      cfg_q.online_reload  <= 8'd10;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      m_valid_q <= m_valid_d;
      cfg_q     <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q <= item_in;
    end
    if (finish) begin
      res_q <= res_new;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000,
                          res_q.zero_command,
                          res_q.drive_enable,
                          res_q.frame_accepted,
                          res_q.current_out,
                          res_q.speed_out,
                          res_q.total_count,
                          res_q.motor_status,
                          res_q.motor_slot};

endmodule

`default_nettype wire
